// ----- sv/shm_pkg.sv -----
`default_nettype none

package shm_pkg;

  // width of one element of the batch
  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

endpackage

`default_nettype wire

// ----- sv/shm_in_if.sv -----
`default_nettype none

interface shm_in_if;

  logic           valid;
  logic           ready;
  shm_pkg::word_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);

endinterface

`default_nettype wire

// ----- sv/shm_out_if.sv -----
`default_nettype none

interface shm_out_if;

  logic           valid;
  logic           ready;
  shm_pkg::word_t sorted_value;
  logic           is_final;

  modport source (output valid, output sorted_value, output is_final, input ready);
  modport sink (input valid, input sorted_value, input is_final, output ready);

endinterface

`default_nettype wire

// ----- sv/shm_ram.sv -----
`default_nettype none

// simple dual-port ram, one write and one registered read
module shm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/sort_halves_and_merge_top.sv -----
`default_nettype none

// channel  dir  modport  payload                                  word moved
// items    in   sink     value (32 signed)                        one element of the batch
// results  out  source   sorted_value (32 signed), is_final (1)   one element, ascending
//
// insertion into the sorted store: one compare and one ram move per cycle
// the element at batch position 0 goes straight in; a later one at position i is
// compared and moved down s (0..i) places, then written to its slot; ready is low meanwhile
// the full batch then leaves in ascending order, each word read in S_EMIT_RD,
// then loaded in S_EMIT_LD; a stall on results holds the sequencer in place
// rst (synchronous) empties the batch and the output register; ram needs no clear
module sort_halves_and_merge_top #(
  parameter int unsigned BATCH_SIZE = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  shm_in_if.sink    items,
  shm_out_if.source results
);

  localparam int unsigned IDX_W = $clog2(BATCH_SIZE);
  localparam int unsigned CNT_W = $clog2(BATCH_SIZE + 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(BATCH_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BATCH_SIZE - 1);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,  // waiting for an element
    S_CMP     = 5'b00010,  // compare held element with its left neighbour
    S_PLACE   = 5'b00100,  // held element goes to the bottom of the store
    S_EMIT_RD = 5'b01000,  // read address for next result
    S_EMIT_LD = 5'b10000   // move read data into output register
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] fill_count;   // elements held in the batch
  logic [IDX_W-1:0] pos;          // free slot of the element being inserted
  logic [IDX_W-1:0] emit_idx;     // next store entry to emit
  shm_pkg::word_t   held;         // element being inserted

  logic           out_valid;
  shm_pkg::word_t out_value;
  logic           out_final;

  // ram ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  shm_pkg::word_t   ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [shm_pkg::WORD_W-1:0] ram_rdata;
  shm_pkg::word_t   neighbour;

  logic in_accept;
  logic shift;       // held element is below its neighbour
  logic insert_done;
  logic out_load;
  logic [CNT_W-1:0] fill_m1;

  assign in_accept   = items.valid && items.ready;
  assign neighbour   = shm_pkg::word_t'(ram_rdata);
  // the single comparator of the design, signed
  assign shift       = held < neighbour;
  assign fill_m1     = fill_count - CNT_W'(1);
  assign out_load    = (state == S_EMIT_LD) && (!out_valid || results.ready);
  assign insert_done = ((state == S_IDLE) && in_accept && (fill_count == '0))
                    || ((state == S_CMP) && !shift)
                    || (state == S_PLACE);

  assign items.ready          = (state == S_IDLE);
  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.is_final     = out_final;

  // ram write and read addressing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = held;
    ram_raddr = emit_idx;
    unique case (state)
      S_IDLE: begin
        // first element goes straight in, otherwise fetch the current top
        ram_we    = in_accept && (fill_count == '0);
        ram_waddr = '0;
        ram_wdata = items.value;
        ram_raddr = fill_m1[IDX_W-1:0];
      end
      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = shift ? neighbour : held;
        // next neighbour down, used only while the move continues
        ram_raddr = pos - IDX_W'(2);
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = held;
      end
      S_EMIT_RD, S_EMIT_LD: begin
        ram_raddr = emit_idx;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && (fill_count != '0)) begin
          state_next = S_CMP;
        end else if (insert_done && (fill_count + CNT_W'(1) == FULL)) begin
          state_next = S_EMIT_RD;
        end
      end
      S_CMP: begin
        if (shift) begin
          state_next = (pos == IDX_W'(1)) ? S_PLACE : S_CMP;
        end else begin
          state_next = (fill_count == FULL) ? S_EMIT_RD : S_IDLE;
        end
      end
      S_PLACE: begin
        state_next = (fill_count == FULL) ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_load) begin
          state_next = (emit_idx == LAST_IDX) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      emit_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (in_accept) begin
        fill_count <= fill_count + CNT_W'(1);
      end else if (out_load && (emit_idx == LAST_IDX)) begin
        fill_count <= '0;
      end

      if (insert_done) begin
        emit_idx <= '0;
      end else if (out_load) begin
        emit_idx <= emit_idx + IDX_W'(1);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      held <= items.value;
      pos  <= fill_count[IDX_W-1:0];
    end else if ((state == S_CMP) && shift) begin
      pos <= pos - IDX_W'(1);
    end
    if (out_load) begin
      out_value <= neighbour;
      out_final <= (emit_idx == LAST_IDX);
    end
  end

  shm_ram #(
    .WIDTH (shm_pkg::WORD_W),
    .DEPTH (BATCH_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the batch count never passes the batch size
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL)
    else $error("batch count beyond batch size");

  // a new element is only taken while the batch still has room
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (fill_count < FULL))
    else $error("element accepted into a full batch");

  // the compare step always has a left neighbour
  a_cmp_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (pos != '0))
    else $error("compare step with no neighbour");

  // once the final word is loaded the batch has been emptied
  a_final_empty: assert property (@(posedge clk) disable iff (rst)
    (out_load && (emit_idx == LAST_IDX)) |=> (fill_count == '0) && out_final)
    else $error("final word left the batch non-empty");

  // emission starts only with a complete batch
  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD) |-> (fill_count == FULL))
    else $error("emission from an incomplete batch");

endmodule

`default_nettype wire

// ----- sim/sort_halves_and_merge_top_tb.sv -----
`default_nettype none

module sort_halves_and_merge_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef shm_pkg::word_t word_t;

  localparam int unsigned BATCH = 16;
  // random batches after the directed one
  localparam int unsigned RANDOM_BATCHES = 23;
  // cycles with no word moved on either channel before the run is given up
  localparam int unsigned QUIET_LIMIT = 2000;
  // tail after the last expected word, to catch stray words
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned PRINT_CAP = 30;

  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_MAX = 32'sh7fff_ffff;

  // one word on the result channel
  typedef struct packed {
    word_t sorted_value;
    logic  is_final;
  } sorted_word_t;

  // one row of the directed batch; the typed columns, where known is set,
  // give the result word at the same position of the output sequence
  typedef struct packed {
    word_t value;
    bit    known;
    word_t sorted_value;
    logic  is_final;
  } dir_row_t;

  // shapes of random batches
  typedef enum int unsigned {
    SPREAD_WIDE,
    SPREAD_TIGHT,
    RUN_UP,
    RUN_DOWN,
    RAIL_MIX,
    HALF_SPLIT
  } batch_shape_t;
  localparam int unsigned SHAPE_COUNT = 6;

  logic clk = 1'b0;
  logic rst;

  shm_in_if  in_bus ();
  shm_out_if out_bus ();

  sort_halves_and_merge_top #(
    .BATCH_SIZE(BATCH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(in_bus),
    .results(out_bus)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: elements of the batch being filled
  word_t        batch_store [BATCH];
  int unsigned  batch_fill;
  int unsigned  batches_sorted;
  // scratch for sorting, shared by predictor and stimulus
  word_t        sort_buf [BATCH];
  // words still owed by the block, oldest first
  sorted_word_t pending_words [$];
  dir_row_t     dir_rows [BATCH];

  int unsigned  mismatch_count;
  int unsigned  words_checked;
  int unsigned  elements_sent;
  int unsigned  quiet_cycles;
  int unsigned  shape_hits [SHAPE_COUNT];
  // set during a stretch where neither side idles
  logic         steady;

  // ascending insertion sort of the scratch buffer, signed compare
  function automatic void sort_buf_up();
    word_t       t;
    int unsigned j;
    for (int unsigned i = 1; i < BATCH; i++) begin
      t = sort_buf[i];
      j = i;
      while (j > 0 && t < sort_buf[j-1]) begin
        sort_buf[j] = sort_buf[j-1];
        j--;
      end
      sort_buf[j] = t;
    end
  endfunction

  // store one accepted element; on the last of a batch, queue the sorted batch
  function automatic void take_element(input word_t v);
    sorted_word_t w;
    batch_store[batch_fill] = v;
    batch_fill++;
    if (batch_fill == BATCH) begin
      sort_buf = batch_store;
      sort_buf_up();
      for (int unsigned k = 0; k < BATCH; k++) begin
        w.sorted_value = sort_buf[k];
        w.is_final     = (k == BATCH - 1);
        // the directed batch takes its typed-in words where given
        if (batches_sorted == 0 && dir_rows[k].known) begin
          w.sorted_value = dir_rows[k].sorted_value;
          w.is_final     = dir_rows[k].is_final;
        end
        pending_words.push_back(w);
      end
      batch_fill = 0;
      batches_sorted++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // compare one accepted result word with the oldest expectation
  task automatic check_word(input word_t got_value, input logic got_final);
    sorted_word_t want;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word %0d final %b", got_value, got_final));
    end else begin
      want = pending_words.pop_front();
      words_checked++;
      if (got_value !== want.sorted_value)
        report_mismatch($sformatf("word %0d: sorted_value %0d, wanted %0d",
                                  words_checked, got_value, want.sorted_value));
      if (got_final !== want.is_final)
        report_mismatch($sformatf("word %0d: is_final %b, wanted %b",
                                  words_checked, got_final, want.is_final));
    end
  endtask

  // drive one element at the falling edge, hold it until the block takes it
  task automatic push_element(input word_t v);
    while (!steady && $urandom_range(99) < 23) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    elements_sent++;
    @(negedge clk);
  endtask

  // build one random batch in the scratch buffer
  task automatic build_batch(input batch_shape_t shape);
    word_t t;
    for (int unsigned k = 0; k < BATCH; k++) begin
      case (shape)
        SPREAD_TIGHT: begin
          // lots of ties, within and across halves
          sort_buf[k] = word_t'($signed($urandom_range(6)) - 3);
        end
        RAIL_MIX: begin
          case ($urandom_range(6))
            0: sort_buf[k] = W_MIN;
            1: sort_buf[k] = W_MAX;
            2: sort_buf[k] = W_MIN + 1;
            3: sort_buf[k] = W_MAX - 1;
            4: sort_buf[k] = '0;
            5: sort_buf[k] = -1;
            default: sort_buf[k] = word_t'($urandom());
          endcase
        end
        HALF_SPLIT: begin
          // first half all above the second
          t = word_t'({1'b0, 31'($urandom())});
          sort_buf[k] = (k < BATCH / 2) ? t : ~t;
        end
        default: begin
          sort_buf[k] = word_t'($urandom());
        end
      endcase
    end
    if (shape == RUN_UP || shape == RUN_DOWN)
      sort_buf_up();
    if (shape == RUN_DOWN) begin
      for (int unsigned k = 0; k < BATCH / 2; k++) begin
        t = sort_buf[k];
        sort_buf[k] = sort_buf[BATCH-1-k];
        sort_buf[BATCH-1-k] = t;
      end
    end
  endtask

  // directed batch: rails, bit patterns and ties across the halves;
  // the two minima come out first and the two maxima last
  initial begin
    dir_rows[0]  = '{W_MAX,          1'b1, W_MIN, 1'b0};
    dir_rows[1]  = '{32'sd0,         1'b1, W_MIN, 1'b0};
    dir_rows[2]  = '{-32'sd1,        1'b0, '0,    1'b0};
    dir_rows[3]  = '{W_MIN,          1'b0, '0,    1'b0};
    dir_rows[4]  = '{32'sd1,         1'b0, '0,    1'b0};
    dir_rows[5]  = '{32'sh5555_5555, 1'b0, '0,    1'b0};
    dir_rows[6]  = '{32'shaaaa_aaaa, 1'b0, '0,    1'b0};
    dir_rows[7]  = '{32'sd5,         1'b0, '0,    1'b0};
    dir_rows[8]  = '{W_MIN,          1'b0, '0,    1'b0};
    dir_rows[9]  = '{32'sd5,         1'b0, '0,    1'b0};
    dir_rows[10] = '{W_MAX,          1'b0, '0,    1'b0};
    dir_rows[11] = '{-32'sd1,        1'b0, '0,    1'b0};
    dir_rows[12] = '{32'sh0000_ffff, 1'b0, '0,    1'b0};
    dir_rows[13] = '{32'shffff_0000, 1'b0, '0,    1'b0};
    dir_rows[14] = '{32'sh1234_5678, 1'b1, W_MAX, 1'b0};
    dir_rows[15] = '{32'shedcb_a987, 1'b1, W_MAX, 1'b1};
  end

  // result side: ready changes at the falling edge only
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= steady || ($urandom_range(99) >= 23);
    end
  end

  // sample both channels at the rising edge, and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
        take_element(in_bus.value);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        check_word(out_bus.sorted_value, out_bus.is_final);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
          || (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved in %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    batch_shape_t shape;
    batch_fill     = 0;
    batches_sorted = 0;
    mismatch_count = 0;
    words_checked  = 0;
    elements_sent  = 0;
    quiet_cycles   = 0;
    for (int unsigned s = 0; s < SHAPE_COUNT; s++) shape_hits[s] = 0;
    steady       <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.value <= '0;
    rst          <= 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed batch
    for (int unsigned r = 0; r < BATCH; r++)
      push_element(dir_rows[r].value);

    // random batches; a stretch in the middle runs with no idling at all
    for (int unsigned b = 0; b < RANDOM_BATCHES; b++) begin
      steady <= (b >= 9 && b < 13);
      shape = batch_shape_t'($urandom_range(SHAPE_COUNT - 1));
      shape_hits[shape]++;
      build_batch(shape);
      for (int unsigned k = 0; k < BATCH; k++)
        push_element(sort_buf[k]);
    end
    in_bus.valid <= 1'b0;
    steady       <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d elements in %0d batches, checked %0d sorted words",
             elements_sent, batches_sorted, words_checked);
    $display("shapes: wide %0d tight %0d up %0d down %0d rails %0d split %0d",
             shape_hits[SPREAD_WIDE], shape_hits[SPREAD_TIGHT], shape_hits[RUN_UP],
             shape_hits[RUN_DOWN], shape_hits[RAIL_MIX], shape_hits[HALF_SPLIT]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
